// ===== rtl/vrt_pkg.sv =====
// shared types, constants and lexing functions for the version range tokenizer
`default_nettype none

package vrt_pkg;

    // position counter saturates at this value
    localparam int unsigned MAX_LENGTH = 65535;
    localparam int unsigned POS_W      = $clog2(MAX_LENGTH + 1);
    localparam int unsigned OUT_POS_W  = 16;
    localparam int unsigned VAL_W      = 64;
    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned MAX_BEATS  = 3;
    localparam int unsigned CNT_W      = $clog2(MAX_BEATS + 1);

    localparam logic [CHAR_W-1:0] CH_LT    = 8'h3C;
    localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;
    localparam logic [CHAR_W-1:0] CH_BAR   = 8'h7C;
    localparam logic [CHAR_W-1:0] CH_CARET = 8'h5E;
    localparam logic [CHAR_W-1:0] CH_TILDE = 8'h7E;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_SP    = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_UC_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UC_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LC_Z  = 8'h7A;

    typedef logic [POS_W-1:0] t_pos;

    typedef enum logic [4:0] {
        TK_UNEXPECTED = 5'd0,
        TK_LE         = 5'd1,
        TK_GE         = 5'd2,
        TK_OR         = 5'd3,
        TK_SPACE      = 5'd4,
        TK_EQ         = 5'd5,
        TK_GT         = 5'd6,
        TK_LT         = 5'd7,
        TK_CARET      = 5'd8,
        TK_TILDE      = 5'd9,
        TK_STAR       = 5'd10,
        TK_DOT        = 5'd11,
        TK_COMMA      = 5'd12,
        TK_HYPHEN     = 5'd13,
        TK_PLUS       = 5'd14,
        TK_ALNUM      = 5'd15,
        TK_NUMERIC    = 5'd16,
        TK_END        = 5'd17
    } t_kind;

    // class of the token still open
    typedef enum logic [1:0] {
        CLS_NONE  = 2'd0,
        CLS_WS    = 2'd1,
        CLS_ALNUM = 2'd2,
        CLS_DIGIT = 2'd3
    } t_cls;

    typedef struct packed {
        t_kind                kind;
        logic [OUT_POS_W-1:0] start_pos;
        logic [OUT_POS_W-1:0] end_pos;
        logic [VAL_W-1:0]     value;
        logic                 ovf;
        logic                 last_of_run;
    } t_tok;

    typedef struct packed {
        t_cls cls;
        t_pos pos;
        t_pos start;
        logic lz;
    } t_lex_st;

    typedef struct packed {
        t_lex_st st;
        logic    emit;
        logic    taken;
        t_tok    tok;
    } t_dec;

    function automatic logic is_ws(input logic [CHAR_W-1:0] c);
        return (c == CH_SP) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        return ((c >= CH_LC_A) && (c <= CH_LC_Z)) || ((c >= CH_UC_A) && (c <= CH_UC_Z));
    endfunction

    function automatic logic is_dig(input logic [CHAR_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic t_pos pos_inc(input t_pos p);
        return (p < POS_W'(MAX_LENGTH)) ? p + POS_W'(1) : p;
    endfunction

    function automatic logic [3:0] digit_val(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] t;
        t = c - CH_ZERO;
        return (t[3:0] > 4'd9) ? 4'd0 : t[3:0];
    endfunction

    function automatic t_kind single_kind(input logic [CHAR_W-1:0] c);
        t_kind k;
        unique case (c)
            CH_EQ:    k = TK_EQ;
            CH_GT:    k = TK_GT;
            CH_LT:    k = TK_LT;
            CH_CARET: k = TK_CARET;
            CH_TILDE: k = TK_TILDE;
            CH_STAR:  k = TK_STAR;
            CH_DOT:   k = TK_DOT;
            CH_COMMA: k = TK_COMMA;
            CH_MINUS: k = TK_HYPHEN;
            CH_PLUS:  k = TK_PLUS;
            default:  k = TK_UNEXPECTED;
        endcase
        return k;
    endfunction

    // acc * 10 + digit, saturating; msb of the result is the overflow flag
    function automatic logic [VAL_W:0] mul_add(input logic [VAL_W-1:0] acc,
                                                input logic ovf,
                                                input logic [CHAR_W-1:0] c);
        logic [VAL_W+3:0] prod;
        logic             ov;
        prod = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + (VAL_W + 4)'(digit_val(c));
        ov   = ovf || (prod[VAL_W+3:VAL_W] != 4'd0);
        return {ov, (ov ? {VAL_W{1'b1}} : prod[VAL_W-1:0])};
    endfunction

    // decide byte x given the byte after it (y, when nv); acc/ovf already hold x
    function automatic t_dec decide(input t_lex_st s,
                                    input logic [CHAR_W-1:0] x,
                                    input logic nv,
                                    input logic [CHAR_W-1:0] y,
                                    input logic [VAL_W-1:0] acc,
                                    input logic ovf);
        t_dec r;
        t_pos p;
        logic done;
        r       = '0;
        r.st    = s;
        p       = s.pos;
        done    = 1'b0;
        if (s.cls == CLS_NONE) begin
            if (nv && (((x == CH_LT) && (y == CH_EQ)) || ((x == CH_GT) && (y == CH_EQ)) ||
                       ((x == CH_BAR) && (y == CH_BAR)))) begin
                r.st.pos        = pos_inc(pos_inc(p));
                r.emit          = 1'b1;
                r.taken         = 1'b1;
                r.tok.kind      = (x == CH_LT) ? TK_LE : ((x == CH_GT) ? TK_GE : TK_OR);
                r.tok.start_pos = OUT_POS_W'(p);
                r.tok.end_pos   = OUT_POS_W'(r.st.pos);
                done            = 1'b1;
            end else begin
                r.st.start = p;
                if (is_ws(x)) begin
                    r.st.cls = CLS_WS;
                end else if (is_letter(x)) begin
                    r.st.cls = CLS_ALNUM;
                end else if (is_dig(x)) begin
                    if ((x == CH_ZERO) && !(nv && is_dig(y))) begin
                        // lone zero is numeric even before a letter
                        r.st.pos        = pos_inc(p);
                        r.emit          = 1'b1;
                        r.tok.kind      = TK_NUMERIC;
                        r.tok.start_pos = OUT_POS_W'(p);
                        r.tok.end_pos   = OUT_POS_W'(r.st.pos);
                        done            = 1'b1;
                    end else begin
                        r.st.cls = CLS_DIGIT;
                        r.st.lz  = (x == CH_ZERO);
                    end
                end else begin
                    r.st.pos        = pos_inc(p);
                    r.emit          = 1'b1;
                    r.tok.kind      = single_kind(x);
                    r.tok.start_pos = OUT_POS_W'(p);
                    r.tok.end_pos   = OUT_POS_W'(r.st.pos);
                    done            = 1'b1;
                end
            end
        end
        if (!done) begin
            r.st.pos        = pos_inc(p);
            r.tok.start_pos = OUT_POS_W'(r.st.start);
            r.tok.end_pos   = OUT_POS_W'(r.st.pos);
            unique case (r.st.cls)
                CLS_WS: begin
                    if (!(nv && is_ws(y))) begin
                        r.emit     = 1'b1;
                        r.tok.kind = TK_SPACE;
                        r.st.cls   = CLS_NONE;
                    end
                end
                CLS_ALNUM: begin
                    if (!(nv && (is_letter(y) || is_dig(y)))) begin
                        r.emit     = 1'b1;
                        r.tok.kind = TK_ALNUM;
                        r.st.cls   = CLS_NONE;
                    end
                end
                CLS_DIGIT: begin
                    if (nv && is_dig(y)) begin
                        r.st.cls = CLS_DIGIT;
                    end else if (nv && is_letter(y)) begin
                        r.st.cls = CLS_ALNUM;
                    end else begin
                        r.emit   = 1'b1;
                        r.st.cls = CLS_NONE;
                        if (r.st.lz) begin
                            r.tok.kind = TK_ALNUM;
                        end else begin
                            r.tok.kind  = TK_NUMERIC;
                            r.tok.value = acc;
                            r.tok.ovf   = ovf;
                        end
                    end
                end
                CLS_NONE: begin
                    r.st.cls = CLS_NONE;
                end
            endcase
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/vrt_step.sv =====
// per-character lexing step: decides lookahead and last byte, packs result beats
`default_nettype none

module vrt_step (
    input  wire logic [vrt_pkg::CHAR_W-1:0] i_char,
    input  wire logic                       i_last,
    input  wire logic                       i_la_valid,
    input  wire logic [vrt_pkg::CHAR_W-1:0] i_la_char,
    input  wire vrt_pkg::t_lex_st           i_st,
    input  wire logic [vrt_pkg::VAL_W-1:0]  i_acc,
    input  wire logic                       i_ovf,
    output vrt_pkg::t_lex_st                o_st,
    output logic                            o_la_valid,
    output logic [vrt_pkg::CHAR_W-1:0]      o_la_char,
    output logic [vrt_pkg::VAL_W-1:0]       o_acc,
    output logic                            o_ovf,
    output vrt_pkg::t_tok                   o_res [vrt_pkg::MAX_BEATS],
    output logic [vrt_pkg::CNT_W-1:0]       o_res_cnt
);

    vrt_pkg::t_dec                d1;
    vrt_pkg::t_dec                d2;
    logic [vrt_pkg::VAL_W:0]      mul;
    logic [vrt_pkg::VAL_W-1:0]    acc_c;
    logic                         ovf_c;
    logic                         use_d2;
    logic                         e1;
    logic                         e2;
    vrt_pkg::t_tok                tok_end;
    vrt_pkg::t_pos                end_pos;

    always_comb begin
        // lookahead byte, decided against the incoming one
        if (i_la_valid) begin
            d1 = vrt_pkg::decide(i_st, i_la_char, 1'b1, i_char, i_acc, i_ovf);
        end else begin
            d1    = '0;
            d1.st = i_st;
        end

        // fold the incoming byte into the digit run (one multiply-add per beat)
        mul = vrt_pkg::mul_add(i_acc, i_ovf, i_char);
        if (d1.st.cls == vrt_pkg::CLS_DIGIT) begin
            acc_c = mul[vrt_pkg::VAL_W-1:0];
            ovf_c = mul[vrt_pkg::VAL_W];
        end else begin
            acc_c = vrt_pkg::VAL_W'(vrt_pkg::digit_val(i_char));
            ovf_c = 1'b0;
        end

        // last byte, nothing after it
        d2     = vrt_pkg::decide(d1.st, i_char, 1'b0, '0, acc_c, ovf_c);
        use_d2 = i_last && !d1.taken;
        end_pos = use_d2 ? d2.st.pos : d1.st.pos;

        tok_end           = '0;
        tok_end.kind      = vrt_pkg::TK_END;
        tok_end.start_pos = vrt_pkg::OUT_POS_W'(end_pos);
        tok_end.end_pos   = vrt_pkg::OUT_POS_W'(end_pos);

        e1 = d1.emit;
        e2 = use_d2 && d2.emit;

        o_res[0] = e1 ? d1.tok : (e2 ? d2.tok : tok_end);
        o_res[1] = (e1 && e2) ? d2.tok : tok_end;
        o_res[2] = tok_end;
        o_res_cnt = vrt_pkg::CNT_W'(e1) + vrt_pkg::CNT_W'(e2) + vrt_pkg::CNT_W'(i_last);
        for (int i = 0; i < vrt_pkg::MAX_BEATS; i++) begin
            o_res[i].last_of_run = (vrt_pkg::CNT_W'(i + 1) == o_res_cnt);
        end

        // end of string returns to the reset state
        if (i_last) begin
            o_st       = '0;
            o_la_valid = 1'b0;
            o_la_char  = '0;
            o_acc      = '0;
            o_ovf      = 1'b0;
        end else begin
            o_st       = d1.st;
            o_la_valid = !d1.taken;
            o_la_char  = i_char;
            o_acc      = acc_c;
            o_ovf      = ovf_c;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/version_range_tokenizer.sv =====
// top level of the version range tokenizer: input register, lexer state, result buffer
`default_nettype none

// Streaming lexer for version-range strings, one character per input beat with a
// last flag. Each accepted character is held in an input register and processed
// combinationally against the lexer state (one byte of lookahead, position,
// open token class and start, decimal accumulator); the resulting tokens, up to
// three per character, drop into a three-entry result buffer that drains one beat
// per cycle unless stalled. A character is accepted every cycle while it yields
// at most one token with no stall; after one that yields more, the input side
// is held until its last token leaves. The accumulator advances by one 64-bit
// multiply-by-ten add per character and is kept one character ahead so the add
// never chains. After the last character an end token is sent and the state
// returns to its reset values, ready for the next string. Positions saturate at
// 65535; numeric values saturate at all ones with the overflow flag set.

module version_range_tokenizer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_char_code,
    input  wire logic        i_is_last,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [4:0]       o_token_kind,
    output logic [15:0]      o_start_pos,
    output logic [15:0]      o_end_pos,
    output logic [63:0]      o_numeric_value,
    output logic             o_value_overflow,
    output logic             o_last_of_run
);

    // input register
    logic                          r_in_valid;
    logic [vrt_pkg::CHAR_W-1:0]    r_in_char;
    logic                          r_in_last;

    // lexer state; accumulator already includes the lookahead digit
    vrt_pkg::t_lex_st              r_st;
    logic                          r_la_valid;
    logic [vrt_pkg::CHAR_W-1:0]    r_la_char;
    logic [vrt_pkg::VAL_W-1:0]     r_acc;
    logic                          r_ovf;

    // result buffer, entry 0 is on the output port
    vrt_pkg::t_tok                 r_ob [vrt_pkg::MAX_BEATS];
    logic [vrt_pkg::CNT_W-1:0]     r_ob_cnt;

    vrt_pkg::t_lex_st              n_st;
    logic                          n_la_valid;
    logic [vrt_pkg::CHAR_W-1:0]    n_la_char;
    logic [vrt_pkg::VAL_W-1:0]     n_acc;
    logic                          n_ovf;
    vrt_pkg::t_tok                 w_res [vrt_pkg::MAX_BEATS];
    logic [vrt_pkg::CNT_W-1:0]     w_res_cnt;

    logic                          w_pop;
    logic                          w_load_ok;
    logic                          w_fire;
    logic                          w_in_acc;

    vrt_step u_step (
        .i_char     (r_in_char),
        .i_last     (r_in_last),
        .i_la_valid (r_la_valid),
        .i_la_char  (r_la_char),
        .i_st       (r_st),
        .i_acc      (r_acc),
        .i_ovf      (r_ovf),
        .o_st       (n_st),
        .o_la_valid (n_la_valid),
        .o_la_char  (n_la_char),
        .o_acc      (n_acc),
        .o_ovf      (n_ovf),
        .o_res      (w_res),
        .o_res_cnt  (w_res_cnt)
    );

    always_comb begin
        w_pop     = (r_ob_cnt != '0) && !i_stall;
        // buffer can take a new character's beats once at most the last one leaves
        w_load_ok = (r_ob_cnt == '0) || ((r_ob_cnt == vrt_pkg::CNT_W'(1)) && w_pop);
        w_fire    = r_in_valid && w_load_ok;
        o_stall   = r_in_valid && !w_load_ok;
        w_in_acc  = i_valid && !o_stall;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_st       <= '0;
            r_la_valid <= 1'b0;
            r_la_char  <= '0;
            r_acc      <= '0;
            r_ovf      <= 1'b0;
            r_ob_cnt   <= '0;
        end else begin
            if (w_in_acc) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_st       <= n_st;
                r_la_valid <= n_la_valid;
                r_la_char  <= n_la_char;
                r_acc      <= n_acc;
                r_ovf      <= n_ovf;
                r_ob_cnt   <= w_res_cnt;
            end else if (w_pop) begin
                r_ob_cnt   <= r_ob_cnt - vrt_pkg::CNT_W'(1);
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_char <= i_char_code;
            r_in_last <= i_is_last;
        end
        if (w_fire) begin
            r_ob <= w_res;
        end else if (w_pop) begin
            for (int i = 0; i < vrt_pkg::MAX_BEATS - 1; i++) begin
                r_ob[i] <= r_ob[i + 1];
            end
        end
    end

    always_comb begin
        o_valid          = (r_ob_cnt != '0);
        o_token_kind     = r_ob[0].kind;
        o_start_pos      = r_ob[0].start_pos;
        o_end_pos        = r_ob[0].end_pos;
        o_numeric_value  = r_ob[0].value;
        o_value_overflow = r_ob[0].ovf;
        o_last_of_run    = r_ob[0].last_of_run;
    end

endmodule

`default_nettype wire
